// ===== sv/kpd_pkg.sv =====
package kpd_pkg;

  localparam logic [3:0]  KEY_NONE       = 4'd0;
  localparam logic [6:0]  SPACE_CHAR     = 7'd32;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

  typedef struct packed {
    logic [3:0]  rows_col_one;
    logic [3:0]  rows_col_two;
    logic [3:0]  rows_col_three;
    logic [31:0] now_ms;
    logic        take_event;
  } in_t;

  typedef struct packed {
    logic [6:0] event_char;
    logic [6:0] held_char;
  } out_t;

  // Classified scan tick as it waits in the queue.
  typedef struct packed {
    logic [3:0]  key;
    logic [31:0] now_ms;
    logic        take_event;
  } work_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Key code to keypad character: codes run down column one, then two, then three.
  function automatic logic [6:0] key_char(input logic [3:0] key);
    logic [6:0] c;
    unique case (key)
      4'd1:    c = 7'h31;  // '1'
      4'd2:    c = 7'h34;  // '4'
      4'd3:    c = 7'h37;  // '7'
      4'd4:    c = 7'h2A;  // '*'
      4'd5:    c = 7'h32;  // '2'
      4'd6:    c = 7'h35;  // '5'
      4'd7:    c = 7'h38;  // '8'
      4'd8:    c = 7'h30;  // '0'
      4'd9:    c = 7'h33;  // '3'
      4'd10:   c = 7'h36;  // '6'
      4'd11:   c = 7'h39;  // '9'
      4'd12:   c = 7'h23;  // '#'
      default: c = SPACE_CHAR;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/kpd_front.sv =====
module kpd_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kpd_pkg::in_t     in_data_i,
  input  kpd_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output kpd_pkg::work_t   push_data_o
);

  // Pressed row in the priority order 1, 4, 2, 3; zero when no row is low.
  function automatic logic [2:0] pick_row(input logic [3:0] levels);
    logic [2:0] r;
    priority if (!levels[0]) r = 3'd1;
    else if (!levels[3])     r = 3'd4;
    else if (!levels[1])     r = 3'd2;
    else if (!levels[2])     r = 3'd3;
    else                     r = 3'd0;
    return r;
  endfunction

  logic [2:0] row_one, row_two, row_three;
  logic [3:0] key;

  assign row_one   = pick_row(in_data_i.rows_col_one);
  assign row_two   = pick_row(in_data_i.rows_col_two);
  assign row_three = pick_row(in_data_i.rows_col_three);

  always_comb begin
    priority if (row_one != 3'd0) key = {1'b0, row_one};
    else if (row_two != 3'd0)     key = {1'b0, row_two} + 4'd4;
    else if (row_three != 3'd0)   key = {1'b0, row_three} + 4'd8;
    else                          key = kpd_pkg::KEY_NONE;
  end

  assign in_ready_o              = !q_stat_i.full;
  assign push_o                  = in_valid_i && in_ready_o;
  assign push_data_o.key         = key;
  assign push_data_o.now_ms      = in_data_i.now_ms;
  assign push_data_o.take_event  = in_data_i.take_event;

endmodule

// ===== sv/kpd_queue.sv =====
module kpd_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kpd_pkg::work_t   push_data_i,
  input  logic             pop_i,
  output kpd_pkg::work_t   head_o,
  output kpd_pkg::q_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  kpd_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== sv/kpd_back.sv =====
module kpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  kpd_pkg::work_t   head_i,
  input  kpd_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kpd_pkg::out_t    out_data_o
);

  logic [15:0]   debounce_q;
  logic [3:0]    last_q, last_d;
  logic [31:0]   change_q, change_d;
  logic [3:0]    stable_q, stable_d;
  logic [3:0]    pend_q, pend_d, pend_upd;
  logic          out_valid_q;
  kpd_pkg::out_t out_q, out_d;
  logic          settled;

  // A new tick is taken whenever the output register is free or being drained.
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    last_d   = head_i.key;
    change_d = (head_i.key != last_q) ? head_i.now_ms : change_q;
    settled  = (head_i.now_ms - change_d) >= {16'b0, debounce_q};
    stable_d = settled ? head_i.key : stable_q;
    pend_upd = pend_q;
    if (settled && (stable_q != head_i.key) && (head_i.key != kpd_pkg::KEY_NONE)) begin
      pend_upd = head_i.key;
    end
    if (head_i.take_event) begin
      out_d.event_char = kpd_pkg::key_char(pend_upd);
      pend_d           = kpd_pkg::KEY_NONE;
    end else begin
      out_d.event_char = kpd_pkg::SPACE_CHAR;
      pend_d           = pend_upd;
    end
    out_d.held_char = kpd_pkg::key_char(stable_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= kpd_pkg::DEBOUNCE_RESET;
      last_q      <= kpd_pkg::KEY_NONE;
      change_q    <= '0;
      stable_q    <= kpd_pkg::KEY_NONE;
      pend_q      <= kpd_pkg::KEY_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        last_q      <= last_d;
        change_q    <= change_d;
        stable_q    <= stable_d;
        pend_q      <= pend_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/keypad_scan_debounce_top.sv =====
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_ready_o   | in_data_i   (kpd_pkg::in_t)
// result  | out       | out_valid_o / out_ready_i | out_data_o  (kpd_pkg::out_t)
// config  | in        | cfg_we_i, no wait         | cfg_wdata_i (debounce_ms)
//
// One scan tick is taken per cycle while the queue is not full. The queue entry is written
// at the input transfer, and the debounce stage registers the result when it pops that entry,
// which it does once the queue holds it and the output register is free or being drained.
// Reset clears the queue, the key state, the event and sets debounce_ms to 20.
// A stalled result holds in the output register; the queue keeps taking ticks until
// QueueDepth of them wait, and only then in_ready_o drops.
module keypad_scan_debounce_top #(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kpd_pkg::out_t out_data_o
);

  // The front finds the first pressed key of the tick and pushes a compact work item.
  // The back pops it, runs the debounce and event logic and registers the result.
  logic             push;
  kpd_pkg::work_t   push_data;
  logic             pop;
  kpd_pkg::work_t   head;
  kpd_pkg::q_stat_t q_stat;

  kpd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue lets the front keep accepting while the result side stalls.
  kpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // The back holds all debounce state, so each tick sees the state the previous one left.
  kpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/kpd_checker.sv =====
module kpd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input kpd_pkg::out_t out_data_o
);

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  // A result that appears from an empty output comes from an input transfer that went straight through the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transfer");

  // A taken event is always a key character, never the same as an idle slot marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_char != kpd_pkg::SPACE_CHAR) |->
      (out_data_o.event_char >= 7'h23))
    else $error("event character out of range");

endmodule

bind keypad_scan_debounce_top kpd_checker u_kpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
